### src/expression_tokenizer_macros.svh
// assertion helpers shared by the tokenizer files
`ifndef EXPRESSION_TOKENIZER_MACROS_SVH
`define EXPRESSION_TOKENIZER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ETOK_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define ETOK_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/etok_pkg.sv
package etok_pkg;

	localparam int SYMBOL_SIZE_DEF  = 64;
	localparam int MAX_EXPR_LEN_DEF = 4096;

	// character codes
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_BTICK  = 8'h60;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// token kinds
	localparam logic [4:0] K_IDENT  = 5'd0;
	localparam logic [4:0] K_INT    = 5'd1;
	localparam logic [4:0] K_FLOAT  = 5'd2;
	localparam logic [4:0] K_STRING = 5'd3;
	localparam logic [4:0] K_PLUS   = 5'd4;
	localparam logic [4:0] K_MINUS  = 5'd5;
	localparam logic [4:0] K_SLASH  = 5'd6;
	localparam logic [4:0] K_STAR   = 5'd7;
	localparam logic [4:0] K_AMP    = 5'd8;
	localparam logic [4:0] K_DOLLAR = 5'd9;
	localparam logic [4:0] K_HASH   = 5'd10;
	localparam logic [4:0] K_BTICK  = 5'd11;
	localparam logic [4:0] K_TILDE  = 5'd12;
	localparam logic [4:0] K_EQ     = 5'd13;
	localparam logic [4:0] K_BANG   = 5'd14;
	localparam logic [4:0] K_GE     = 5'd15;
	localparam logic [4:0] K_LE     = 5'd16;
	localparam logic [4:0] K_GT     = 5'd17;
	localparam logic [4:0] K_LT     = 5'd18;
	// op_kind answer for a byte that is no single-character operator
	localparam logic [4:0] K_NONE   = 5'd0;

	// end statuses
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_IDENT_LONG  = 3'd1;
	localparam logic [2:0] ST_NUMBER_LONG = 3'd2;
	localparam logic [2:0] ST_STRING_LONG = 3'd3;
	localparam logic [2:0] ST_UNTERM      = 3'd4;
	localparam logic [2:0] ST_EXPECT      = 3'd5;

	typedef struct packed {
		logic [4:0]  kind;
		logic [11:0] start;
		logic [5:0]  length;
		logic        is_final;
		logic [2:0]  status;
		logic [11:0] total;
		logic        run_last;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    res0;
		result_t    res1;
	} pair_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
	endfunction

	function automatic logic is_ident_char(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == CH_USCORE);
	endfunction

	function automatic logic [4:0] op_kind(input logic [7:0] c);
		logic [4:0] k;
		unique case (c)
			CH_PLUS:   k = K_PLUS;
			CH_MINUS:  k = K_MINUS;
			CH_SLASH:  k = K_SLASH;
			CH_STAR:   k = K_STAR;
			CH_AMP:    k = K_AMP;
			CH_DOLLAR: k = K_DOLLAR;
			CH_HASH:   k = K_HASH;
			CH_BTICK:  k = K_BTICK;
			CH_TILDE:  k = K_TILDE;
			CH_EQ:     k = K_EQ;
			CH_BANG:   k = K_BANG;
			default:   k = K_NONE;
		endcase
		return k;
	endfunction

	// operands take one from the balance, most operators add one
	function automatic logic [7:0] bal_delta(input logic [4:0] kind);
		logic [7:0] d;
		priority if (kind <= K_STRING) begin
			d = 8'hFF;
		end else if (((kind >= K_AMP) && (kind <= K_TILDE)) || (kind == K_BANG)) begin
			d = 8'h00;
		end else begin
			d = 8'h01;
		end
		return d;
	endfunction

	function automatic logic [11:0] tok_inc(input logic [11:0] t);
		return (t == 12'hFFF) ? t : t + 12'd1;
	endfunction

endpackage

### src/etok_scan.sv
`include "expression_tokenizer_macros.svh"

module etok_scan #(
	parameter int SYMBOL_SIZE  = etok_pkg::SYMBOL_SIZE_DEF,
	parameter int MAX_EXPR_LEN = etok_pkg::MAX_EXPR_LEN_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_v,
	input  logic [7:0]      item_char,
	input  logic            item_end,
	output etok_pkg::pair_t pair
);

	localparam int CW = $clog2(SYMBOL_SIZE);
	localparam int PW = $clog2(MAX_EXPR_LEN);

	typedef enum logic [2:0] {
		M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_MINUS, M_GT, M_LT, M_ERROR
	} mode_t;

	mode_t           mode_q, mode_d;
	logic [PW-1:0]   begin_q, begin_d;
	logic [CW-1:0]   chars_q, chars_d;
	logic            seen_q, seen_d;
	logic            ldot_q, ldot_d;
	logic            pbs_q, pbs_d;
	logic [7:0]      bal_q, bal_d;
	logic [PW-1:0]   pos_q, pos_d;
	logic [11:0]     tok_q, tok_d;
	logic [2:0]      err_q, err_d;

	logic            full;
	logic            fall;
	logic            a_v, b_v, is_fin;
	logic [4:0]      a_kind, b_kind;
	logic [11:0]     a_start, b_start;
	logic [5:0]      a_len;
	logic [7:0]      bal_a;
	logic [11:0]     tok_a;
	logic [2:0]      fin_status;
	etok_pkg::result_t res_a, res_b, res_f;

	function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
		return (p == PW'(MAX_EXPR_LEN - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full = (chars_q >= CW'(SYMBOL_SIZE - 1));

	always_comb begin
		mode_d  = mode_q;
		begin_d = begin_q;
		chars_d = chars_q;
		seen_d  = seen_q;
		ldot_d  = ldot_q;
		pbs_d   = pbs_q;
		pos_d   = pos_q;
		err_d   = err_q;
		fall    = 1'b0;
		a_v     = 1'b0;
		a_kind  = etok_pkg::K_IDENT;
		a_start = 12'(begin_q);
		a_len   = 6'(chars_q);
		b_v     = 1'b0;
		b_kind  = etok_pkg::K_NONE;
		b_start = 12'(pos_q);
		is_fin  = 1'b0;
		if (item_v && !item_end) begin
			pos_d = next_pos(pos_q);
			unique case (mode_q)
				M_ERROR: begin
				end
				M_STRING: begin
					if ((item_char == etok_pkg::CH_QUOTE) && !pbs_q) begin
						a_v    = 1'b1;
						a_kind = etok_pkg::K_STRING;
						mode_d = M_IDLE;
					end else if (full) begin
						mode_d = M_ERROR;
						err_d  = etok_pkg::ST_STRING_LONG;
					end else begin
						chars_d = chars_q + CW'(1);
						pbs_d   = (item_char == etok_pkg::CH_BSLASH);
					end
				end
				M_IDENT: begin
					if (etok_pkg::is_ident_char(item_char)) begin
						if (full) begin
							mode_d = M_ERROR;
							err_d  = etok_pkg::ST_IDENT_LONG;
						end else begin
							chars_d = chars_q + CW'(1);
						end
					end else begin
						fall = 1'b1;
					end
				end
				M_NUMBER: begin
					if (etok_pkg::is_digit(item_char) ||
					    ((item_char == etok_pkg::CH_DOT) && !ldot_q)) begin
						if (full) begin
							mode_d = M_ERROR;
							err_d  = etok_pkg::ST_NUMBER_LONG;
						end else begin
							chars_d = chars_q + CW'(1);
							seen_d  = seen_q || (item_char == etok_pkg::CH_DOT);
							ldot_d  = (item_char == etok_pkg::CH_DOT);
						end
					end else begin
						fall = 1'b1;
					end
				end
				M_MINUS: begin
					if (etok_pkg::is_digit(item_char)) begin
						mode_d = M_NUMBER;
						seen_d = 1'b0;
						ldot_d = 1'b0;
						if (full) begin
							mode_d = M_ERROR;
							err_d  = etok_pkg::ST_NUMBER_LONG;
						end else begin
							chars_d = chars_q + CW'(1);
						end
					end else begin
						fall = 1'b1;
					end
				end
				M_GT, M_LT: begin
					if (item_char == etok_pkg::CH_EQ) begin
						a_v    = 1'b1;
						a_kind = (mode_q == M_GT) ? etok_pkg::K_GE : etok_pkg::K_LE;
						a_len  = 6'd2;
						mode_d = M_IDLE;
					end else begin
						fall = 1'b1;
					end
				end
				M_IDLE: begin
					fall = 1'b1;
				end
			endcase
		end

		// pending token flush, on a breaking character or on the end marker
		if (fall || (item_v && item_end && (mode_q != M_ERROR) && (mode_q != M_STRING))) begin
			unique case (mode_q)
				M_IDENT: begin
					a_v    = 1'b1;
					a_kind = etok_pkg::K_IDENT;
				end
				M_NUMBER: begin
					a_v    = 1'b1;
					a_kind = seen_q ? etok_pkg::K_FLOAT : etok_pkg::K_INT;
				end
				M_MINUS: begin
					a_v    = 1'b1;
					a_kind = etok_pkg::K_MINUS;
					a_len  = 6'd1;
				end
				M_GT: begin
					a_v    = 1'b1;
					a_kind = etok_pkg::K_GT;
					a_len  = 6'd1;
				end
				M_LT: begin
					a_v    = 1'b1;
					a_kind = etok_pkg::K_LT;
					a_len  = 6'd1;
				end
				default: begin
				end
			endcase
		end

		// fresh start on the breaking character
		if (fall) begin
			begin_d = pos_q;
			chars_d = CW'(1);
			seen_d  = 1'b0;
			ldot_d  = 1'b0;
			pbs_d   = 1'b0;
			priority if (etok_pkg::is_alpha(item_char) || (item_char == etok_pkg::CH_USCORE)) begin
				mode_d = M_IDENT;
			end else if (etok_pkg::is_digit(item_char)) begin
				mode_d = M_NUMBER;
			end else if (item_char == etok_pkg::CH_MINUS) begin
				mode_d = M_MINUS;
			end else if (item_char == etok_pkg::CH_QUOTE) begin
				mode_d  = M_STRING;
				begin_d = next_pos(pos_q);
				chars_d = '0;
			end else if (item_char == etok_pkg::CH_GT) begin
				mode_d = M_GT;
			end else if (item_char == etok_pkg::CH_LT) begin
				mode_d = M_LT;
			end else begin
				mode_d  = M_IDLE;
				chars_d = '0;
				b_kind  = etok_pkg::op_kind(item_char);
				b_v     = (b_kind != etok_pkg::K_NONE);
			end
		end

		bal_a = a_v ? bal_q + etok_pkg::bal_delta(a_kind) : bal_q;
		tok_a = a_v ? etok_pkg::tok_inc(tok_q) : tok_q;
		bal_d = b_v ? bal_a + etok_pkg::bal_delta(b_kind) : bal_a;
		tok_d = b_v ? etok_pkg::tok_inc(tok_a) : tok_a;

		priority if (mode_q == M_ERROR) begin
			fin_status = err_q;
		end else if (mode_q == M_STRING) begin
			fin_status = etok_pkg::ST_UNTERM;
		end else if (bal_a != 8'd0) begin
			fin_status = etok_pkg::ST_EXPECT;
		end else begin
			fin_status = etok_pkg::ST_OK;
		end

		// end marker returns everything to the reset picture
		if (item_v && item_end) begin
			is_fin  = 1'b1;
			mode_d  = M_IDLE;
			begin_d = '0;
			chars_d = '0;
			seen_d  = 1'b0;
			ldot_d  = 1'b0;
			pbs_d   = 1'b0;
			bal_d   = 8'd1;
			pos_d   = '0;
			tok_d   = '0;
			err_d   = etok_pkg::ST_OK;
		end
	end

	always_comb begin
		res_a          = '0;
		res_a.kind     = a_kind;
		res_a.start    = a_start;
		res_a.length   = a_len;
		res_b          = '0;
		res_b.kind     = b_kind;
		res_b.start    = b_start;
		res_b.length   = 6'd1;
		res_f          = '0;
		res_f.is_final = 1'b1;
		res_f.status   = fin_status;
		res_f.total    = tok_a;

		pair.cnt  = 2'(a_v) + 2'(b_v) + 2'(is_fin);
		pair.res0 = a_v ? res_a : (b_v ? res_b : res_f);
		pair.res1 = (a_v && b_v) ? res_b : res_f;
		pair.res0.run_last = (pair.cnt == 2'd1);
		pair.res1.run_last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			begin_q <= '0;
			chars_q <= '0;
			seen_q  <= 1'b0;
			ldot_q  <= 1'b0;
			pbs_q   <= 1'b0;
			bal_q   <= 8'd1;
			pos_q   <= '0;
			tok_q   <= '0;
			err_q   <= etok_pkg::ST_OK;
		end else if (item_v) begin
			mode_q  <= mode_d;
			begin_q <= begin_d;
			chars_q <= chars_d;
			seen_q  <= seen_d;
			ldot_q  <= ldot_d;
			pbs_q   <= pbs_d;
			bal_q   <= bal_d;
			pos_q   <= pos_d;
			tok_q   <= tok_d;
			err_q   <= err_d;
		end
	end

	`ETOK_ASSERT_NXT(a_end_clears, item_v && item_end, (mode_q == M_IDLE) && (pos_q == '0) && (bal_q == 8'd1), "end marker did not restore the idle state")
	`ETOK_ASSERT_IMP(a_error_silent, item_v && !item_end && (mode_q == M_ERROR), pair.cnt == 2'd0, "token emitted after an overlong value")

endmodule

### src/etok_outbuf.sv
`include "expression_tokenizer_macros.svh"

module etok_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  etok_pkg::pair_t   pair,
	output logic              room,
	output logic              res_valid,
	input  logic              res_stall,
	output etok_pkg::result_t head
);

	etok_pkg::result_t slot0_q, slot1_q;
	logic [1:0]        cnt_q;
	logic              take;

	assign take      = (cnt_q != 2'd0) && !res_stall;
	assign room      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && take);
	assign res_valid = (cnt_q != 2'd0);
	assign head      = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load && (pair.cnt != 2'd0)) begin
			cnt_q <= pair.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (load && (pair.cnt != 2'd0)) begin
			slot0_q <= pair.res0;
			slot1_q <= pair.res1;
		end else if (take) begin
			slot0_q <= slot1_q;
		end
	end

	`ETOK_ASSERT_IMP(a_pair_first_not_last, cnt_q == 2'd2, !slot0_q.run_last, "first of two results marked last")
	`ETOK_ASSERT_NXT(a_drain_step, take && (cnt_q == 2'd2), cnt_q == 2'd1, "second result lost while draining")

endmodule

### src/expression_tokenizer.sv
// streaming expression lexer: one character (or the end marker) per transfer in,
// tokens out as kind, start offset and length, then one status result closing the
// expression. a character is held in the input register; when it moves on, the lexer
// decides its results and they are loaded into the two-slot result buffer, which
// presents them. the sustained rate is one character per cycle while the token channel
// is not stalled; a character that causes two results (a flushed token plus an operator,
// or a flush plus the end status) fills both slots, and the following character waits
// in the input register until the buffer drains. the lexer state itself never holds
// the flow, so the result buffer drain is the only limit.
`include "expression_tokenizer_macros.svh"

module expression_tokenizer #(
	parameter int SYMBOL_SIZE  = etok_pkg::SYMBOL_SIZE_DEF,
	parameter int MAX_EXPR_LEN = etok_pkg::MAX_EXPR_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// character channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  char_code,
	input  logic        end_marker,
	// token channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [4:0]  token_kind,
	output logic [11:0] token_start,
	output logic [5:0]  token_length,
	output logic        is_final,
	output logic [2:0]  status,
	output logic [11:0] token_total,
	output logic        run_last
);

	// input register stage
	logic              s1_valid;
	logic [7:0]        s1_char;
	logic              s1_end;

	logic              room;
	logic              advance;
	logic              in_take;
	etok_pkg::pair_t   pair;
	etok_pkg::result_t head;

	// the held character moves on only when the buffer can take two results
	assign advance    = s1_valid && room;
	assign item_stall = s1_valid && !room;
	assign in_take    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_take) begin
			s1_valid <= 1'b1;
		end else if (advance) begin
			s1_valid <= 1'b0;
		end
	end

	// payload of the input register, no reset
	always_ff @(posedge clk) begin
		if (in_take) begin
			s1_char <= char_code;
			s1_end  <= end_marker;
		end
	end

	// lexer state and per-character token decisions
	etok_scan #(
		.SYMBOL_SIZE  (SYMBOL_SIZE),
		.MAX_EXPR_LEN (MAX_EXPR_LEN)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_v    (advance),
		.item_char (s1_char),
		.item_end  (s1_end),
		.pair      (pair)
	);

	// result register, up to two results per character
	etok_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.pair      (pair),
		.room      (room),
		.res_valid (result_valid),
		.res_stall (result_stall),
		.head      (head)
	);

	assign token_kind   = head.kind;
	assign token_start  = head.start;
	assign token_length = head.length;
	assign is_final     = head.is_final;
	assign status       = head.status;
	assign token_total  = head.total;
	assign run_last     = head.run_last;

	`ETOK_ASSERT_NXT(a_s1_hold, s1_valid && !room, s1_valid && $stable(s1_char) && $stable(s1_end), "held character changed before processing")

endmodule

### tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import etok_pkg::*;

	// longest value the lexer keeps before it flags the symbol as too long
	localparam int VALUE_MAX    = SYMBOL_SIZE_DEF - 1;
	// cycles without any transfer on either channel before the run is abandoned
	localparam int STALL_LIMIT  = 20000;
	// length of the deliberate output hold-off
	localparam int HOLD_CYCLES  = 300;
	// extra wait after the owed results have drained
	localparam int TAIL_CYCLES  = 16;

	// scanner states of the predictor
	typedef enum logic [2:0] {
		SM_IDLE, SM_IDENT, SM_NUMBER, SM_STRING, SM_MINUS, SM_GT, SM_LT, SM_ERROR
	} scan_state_e;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	logic [7:0]  char_code    = 8'd0;
	logic        end_marker   = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [4:0]  token_kind;
	logic [11:0] token_start;
	logic [5:0]  token_length;
	logic        is_final;
	logic [2:0]  status;
	logic [11:0] token_total;
	logic        run_last;

	// idling controls, in percent of cycles
	int sender_idle_pct   = 0;
	int receiver_stall_pct = 0;

	// hold-off request: bumped by the test, noticed by the stall process
	int hold_seq  = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// bookkeeping
	int fail_count     = 0;
	int items_sent     = 0;
	int tokens_checked = 0;
	int finals_checked = 0;
	int idle_cycles    = 0;

	// tokens still owed by the block, oldest first
	result_t expected_tokens[$];
	// results caused by the character being predicted
	result_t step_results[$];
	// characters of the expression being built
	logic [7:0] text_buf[$];

	// predictor state
	scan_state_e lex_mode;
	logic [11:0] lex_begin;
	int          lex_chars;
	logic        lex_dot;
	logic        lex_last_dot;
	logic        lex_bslash;
	logic [7:0]  lex_balance;
	logic [11:0] lex_pos;
	logic [11:0] lex_tokens;
	logic [2:0]  lex_err;

	expression_tokenizer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.char_code    (char_code),
		.end_marker   (end_marker),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.is_final     (is_final),
		.status       (status),
		.token_total  (token_total),
		.run_last     (run_last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// character classes and operator codes
	// ---------------------------------------------------------------

	function automatic logic char_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic char_letter(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic char_in_ident(input logic [7:0] c);
		return char_letter(c) || char_digit(c) || (c == CH_USCORE);
	endfunction

	// kind of a single-character operator, K_NONE when the byte is none
	function automatic logic [4:0] operator_kind(input logic [7:0] c);
		case (c)
			CH_PLUS:   return K_PLUS;
			CH_MINUS:  return K_MINUS;
			CH_SLASH:  return K_SLASH;
			CH_STAR:   return K_STAR;
			CH_AMP:    return K_AMP;
			CH_DOLLAR: return K_DOLLAR;
			CH_HASH:   return K_HASH;
			CH_BTICK:  return K_BTICK;
			CH_TILDE:  return K_TILDE;
			CH_EQ:     return K_EQ;
			CH_BANG:   return K_BANG;
			default:   return K_NONE;
		endcase
	endfunction

	// offset of the next character, wrapping at the expression length limit
	function automatic logic [11:0] pos_after(input logic [11:0] p);
		return (int'(p) + 1 >= MAX_EXPR_LEN_DEF) ? 12'd0 : p + 12'd1;
	endfunction

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	function automatic void lex_clear();
		lex_mode     = SM_IDLE;
		lex_begin    = '0;
		lex_chars    = 0;
		lex_dot      = 1'b0;
		lex_last_dot = 1'b0;
		lex_bslash   = 1'b0;
		lex_balance  = 8'd1;
		lex_pos      = '0;
		lex_tokens   = '0;
		lex_err      = ST_OK;
	endfunction

	// one token out; operands lower the balance, binary operators raise it
	function automatic void put_token(input logic [4:0] kind, input logic [11:0] start,
			input int len);
		result_t r;
		r        = '0;
		r.kind   = kind;
		r.start  = start;
		r.length = len[5:0];
		step_results.push_back(r);
		if (lex_tokens != 12'hFFF)
			lex_tokens = lex_tokens + 12'd1;
		if (kind <= K_STRING)
			lex_balance = lex_balance - 8'd1;
		else if (!(((kind >= K_AMP) && (kind <= K_TILDE)) || (kind == K_BANG)))
			lex_balance = lex_balance + 8'd1;
	endfunction

	function automatic logic value_grows();
		if (lex_chars >= VALUE_MAX)
			return 1'b0;
		lex_chars++;
		return 1'b1;
	endfunction

	function automatic void raise_error(input logic [2:0] code);
		lex_err  = code;
		lex_mode = SM_ERROR;
	endfunction

	function automatic void flush_pending();
		case (lex_mode)
			SM_IDENT:  put_token(K_IDENT, lex_begin, lex_chars);
			SM_NUMBER: put_token(lex_dot ? K_FLOAT : K_INT, lex_begin, lex_chars);
			SM_MINUS:  put_token(K_MINUS, lex_begin, 1);
			SM_GT:     put_token(K_GT, lex_begin, 1);
			SM_LT:     put_token(K_LT, lex_begin, 1);
			default: ;
		endcase
		lex_mode = SM_IDLE;
	endfunction

	// a character that continues no pending token
	function automatic void begin_token(input logic [7:0] c);
		logic [4:0] k;
		lex_begin    = lex_pos;
		lex_chars    = 1;
		lex_dot      = 1'b0;
		lex_last_dot = 1'b0;
		lex_bslash   = 1'b0;
		if (char_letter(c) || c == CH_USCORE) begin
			lex_mode = SM_IDENT;
		end else if (char_digit(c)) begin
			lex_mode = SM_NUMBER;
		end else if (c == CH_MINUS) begin
			lex_mode = SM_MINUS;
		end else if (c == CH_QUOTE) begin
			lex_mode  = SM_STRING;
			lex_begin = pos_after(lex_pos);
			lex_chars = 0;
		end else if (c == CH_GT) begin
			lex_mode = SM_GT;
		end else if (c == CH_LT) begin
			lex_mode = SM_LT;
		end else begin
			lex_mode  = SM_IDLE;
			lex_chars = 0;
			k = operator_kind(c);
			if (k != K_NONE)
				put_token(k, lex_pos, 1);
		end
	endfunction

	function automatic void lex_char(input logic [7:0] c);
		case (lex_mode)
			SM_ERROR: return;
			SM_STRING: begin
				if (c == CH_QUOTE && !lex_bslash) begin
					put_token(K_STRING, lex_begin, lex_chars);
					lex_mode = SM_IDLE;
				end else if (!value_grows()) begin
					raise_error(ST_STRING_LONG);
				end else begin
					lex_bslash = (c == CH_BSLASH);
				end
				return;
			end
			SM_IDENT: begin
				if (char_in_ident(c)) begin
					if (!value_grows())
						raise_error(ST_IDENT_LONG);
					return;
				end
			end
			SM_NUMBER: begin
				if (char_digit(c) || (c == CH_DOT && !lex_last_dot)) begin
					if (!value_grows()) begin
						raise_error(ST_NUMBER_LONG);
						return;
					end
					if (c == CH_DOT)
						lex_dot = 1'b1;
					lex_last_dot = (c == CH_DOT);
					return;
				end
			end
			SM_MINUS: begin
				if (char_digit(c)) begin
					lex_mode     = SM_NUMBER;
					lex_dot      = 1'b0;
					lex_last_dot = 1'b0;
					if (!value_grows())
						raise_error(ST_NUMBER_LONG);
					return;
				end
			end
			SM_GT, SM_LT: begin
				if (c == CH_EQ) begin
					put_token((lex_mode == SM_GT) ? K_GE : K_LE, lex_begin, 2);
					lex_mode = SM_IDLE;
					return;
				end
			end
			default: ;
		endcase
		flush_pending();
		begin_token(c);
	endfunction

	// works out what one accepted transfer owes and queues it
	function automatic void predict_item(input logic [7:0] c, input logic e);
		result_t r;
		logic [2:0] st;
		step_results.delete();
		if (e) begin
			if (lex_mode == SM_ERROR) begin
				st = lex_err;
			end else if (lex_mode == SM_STRING) begin
				st = ST_UNTERM;
			end else begin
				flush_pending();
				st = (lex_balance != 8'd0) ? ST_EXPECT : ST_OK;
			end
			r          = '0;
			r.is_final = 1'b1;
			r.status   = st;
			r.total    = lex_tokens;
			step_results.push_back(r);
			lex_clear();
		end else begin
			lex_char(c);
			lex_pos = pos_after(lex_pos);
		end
		// last result of this transfer carries the run marker
		if (step_results.size() > 0) begin
			r = step_results.pop_back();
			r.run_last = 1'b1;
			step_results.push_back(r);
		end
		foreach (step_results[i])
			expected_tokens.push_back(step_results[i]);
	endfunction

	// ---------------------------------------------------------------
	// character channel
	// ---------------------------------------------------------------

	// one transfer; valid stays high into the next item unless a gap is drawn
	task automatic send_char(input logic [7:0] c, input logic e);
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		item_valid <= 1'b1;
		char_code  <= c;
		end_marker <= e;
		do @(posedge clk); while (item_stall);
		predict_item(c, e);
		items_sent++;
	endtask

	// end of expression; the character byte is a don't-care, so vary it
	task automatic send_end();
		send_char(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	// ---------------------------------------------------------------
	// token channel: stall generation, checking, watchdog
	// ---------------------------------------------------------------

	// random stall, overridden by a counted hold-off when one is requested
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen    <= hold_seq;
			hold_left    <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= (receiver_stall_pct != 0)
				&& ($urandom_range(99) < receiver_stall_pct);
		end
	end

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// every result transfer against the oldest owed token
	always @(posedge clk) begin : check_tokens
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_tokens.size() == 0) begin
				$error("result with nothing owed: kind %0d start %0d final %0d",
					token_kind, token_start, is_final);
				fail_count++;
			end else begin
				want = expected_tokens.pop_front();
				check_field("token_kind", want.kind, token_kind);
				check_field("token_start", want.start, token_start);
				check_field("token_length", want.length, token_length);
				check_field("is_final", want.is_final, is_final);
				check_field("status", want.status, status);
				check_field("token_total", want.total, token_total);
				check_field("run_last", want.run_last, run_last);
				if (want.is_final)
					finals_checked++;
				else
					tokens_checked++;
			end
		end
	end

	// gives up when neither channel has moved for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// random expression builder
	// ---------------------------------------------------------------

	// mostly short values, now and then around the symbol size limit
	function automatic int pick_len();
		if ($urandom_range(19) == 0)
			return $urandom_range(VALUE_MAX - 5, VALUE_MAX + 3);
		return $urandom_range(1, 6);
	endfunction

	function automatic logic [7:0] pick_ident_char();
		case ($urandom_range(3))
			0:       return 8'($urandom_range("a", "z"));
			1:       return 8'($urandom_range("A", "Z"));
			2:       return 8'($urandom_range("0", "9"));
			default: return CH_USCORE;
		endcase
	endfunction

	task automatic add_ident();
		int n;
		logic [7:0] c;
		n = pick_len();
		do c = pick_ident_char(); while (char_digit(c));
		text_buf.push_back(c);
		for (int i = 1; i < n; i++)
			text_buf.push_back(pick_ident_char());
	endtask

	// optional sign, digits with the odd dot, occasionally a doubled dot
	task automatic add_number();
		int n;
		n = pick_len();
		if ($urandom_range(3) == 0)
			text_buf.push_back(CH_MINUS);
		text_buf.push_back(8'($urandom_range("0", "9")));
		for (int i = 1; i < n; i++) begin
			if ($urandom_range(5) == 0) begin
				text_buf.push_back(CH_DOT);
				if ($urandom_range(7) == 0)
					text_buf.push_back(CH_DOT);
			end
			text_buf.push_back(8'($urandom_range("0", "9")));
		end
	endtask

	// quoted string with escaped quotes, doubled backslashes and any byte
	task automatic add_string(input logic closed);
		int n;
		logic [7:0] c;
		n = pick_len() - 1;
		text_buf.push_back(CH_QUOTE);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(15))
				0: begin
					text_buf.push_back(CH_BSLASH);
					text_buf.push_back(CH_QUOTE);
				end
				1: begin
					text_buf.push_back(CH_BSLASH);
					text_buf.push_back(CH_BSLASH);
				end
				default: begin
					c = 8'($urandom_range(255));
					if (c == CH_QUOTE || c == CH_BSLASH)
						c = "x";
					text_buf.push_back(c);
				end
			endcase
		end
		if (closed)
			text_buf.push_back(CH_QUOTE);
	endtask

	task automatic add_operand();
		case ($urandom_range(3))
			0:       add_ident();
			1, 2:    add_number();
			default: add_string(1'b1);
		endcase
	endtask

	task automatic add_unary();
		case ($urandom_range(5))
			0:       text_buf.push_back(CH_AMP);
			1:       text_buf.push_back(CH_DOLLAR);
			2:       text_buf.push_back(CH_HASH);
			3:       text_buf.push_back(CH_BTICK);
			4:       text_buf.push_back(CH_TILDE);
			default: text_buf.push_back(CH_BANG);
		endcase
	endtask

	task automatic add_binary();
		case ($urandom_range(8))
			0: text_buf.push_back(CH_PLUS);
			1: text_buf.push_back(CH_MINUS);
			2: text_buf.push_back(CH_SLASH);
			3: text_buf.push_back(CH_STAR);
			4: text_buf.push_back(CH_EQ);
			5: text_buf.push_back(CH_GT);
			6: text_buf.push_back(CH_LT);
			7: begin
				text_buf.push_back(CH_GT);
				text_buf.push_back(CH_EQ);
			end
			default: begin
				text_buf.push_back(CH_LT);
				text_buf.push_back(CH_EQ);
			end
		endcase
	endtask

	// nothing, a space, or a byte that starts no token
	task automatic add_gap();
		case ($urandom_range(3))
			2:       text_buf.push_back(" ");
			3:       text_buf.push_back(8'($urandom_range(128, 255)));
			default: ;
		endcase
	endtask

	// mostly operand (op operand)*, sometimes damaged on purpose
	task automatic send_random_expr();
		int terms;
		int damage;
		int skip_at;
		text_buf.delete();
		skip_at = -1;
		if ($urandom_range(29) == 0) begin
			send_end();
			return;
		end
		terms = $urandom_range(1, 5);
		for (int i = 0; i < terms; i++) begin
			if ($urandom_range(3) == 0)
				add_unary();
			add_operand();
			if (i < terms - 1) begin
				add_gap();
				add_binary();
				add_gap();
			end
		end
		damage = $urandom_range(9);
		case (damage)
			1: add_string(1'b0);
			2: add_binary();
			3: skip_at = $urandom_range(text_buf.size() - 1);
			default: ;
		endcase
		foreach (text_buf[i]) begin
			// noisy expressions get stray bytes of any value
			if (damage == 0 && $urandom_range(7) == 0)
				send_char(8'($urandom_range(255)), 1'b0);
			if (i != skip_at)
				send_char(text_buf[i], 1'b0);
		end
		send_end();
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// every single operator, the two-character compares, > and < flushed by
	// the next byte and by the end marker
	task automatic test_operators();
		send_text("+-/*&$#");
		send_char(CH_BTICK, 1'b0);
		send_text("~=!");
		send_end();
		send_text(">=<=><");
		send_end();
	endtask

	// signed numbers, repeated dots, a doubled dot and a lone trailing minus
	task automatic test_numbers();
		send_text("-12 1.2.3 1..9-a -");
		send_end();
	endtask

	// empty string, escaped quote after one and after two backslashes,
	// zero and top bytes kept inside a string, then one left open
	task automatic test_strings();
		send_text("\"\"\"a\\\"b\\\\\"c\"");
		send_char(CH_QUOTE, 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(CH_QUOTE, 1'b0);
		send_end();
		send_text("x \"ab");
		send_end();
	endtask

	// skipped bytes ending tokens, a lone dot, and an empty expression
	task automatic test_skipped_bytes();
		send_text("ab");
		send_char(8'h00, 1'b0);
		send_text("c1");
		send_char(8'h80, 1'b0);
		send_text(" .7_q");
		send_end();
		send_end();
	endtask

	// balance wrapping all the way round back to zero
	task automatic test_wide_counts();
		repeat (255) send_char(CH_PLUS, 1'b0);
		send_end();
	endtask

	task automatic test_random_expressions(input int count);
		int first;
		first = items_sent;
		while (items_sent - first < count)
			send_random_expr();
	endtask

	// long output hold-off while characters keep coming, so the input backs up
	task automatic test_output_hold();
		hold_seq <= hold_seq + 1;
		repeat (3) send_random_expr();
	endtask

	task automatic set_idling(input int send_pct, input int stall_pct);
		sender_idle_pct    = send_pct;
		receiver_stall_pct <= stall_pct;
	endtask

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------

	initial begin
		lex_clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no idling: directed cases first
		set_idling(0, 0);
		test_operators();
		test_numbers();
		test_strings();
		test_skipped_bytes();
		test_wide_counts();
		test_random_expressions(370);

		// sparse input
		set_idling(81, 0);
		test_random_expressions(370);

		// heavy output stalling, with one long hold-off
		set_idling(0, 81);
		test_output_hold();
		test_random_expressions(370);

		// light idling on both sides
		set_idling(12, 12);
		test_random_expressions(370);

		item_valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_tokens.size() != 0) begin
			$error("%0d results never arrived", expected_tokens.size());
			fail_count++;
		end

		$display("run covered %0d character transfers, %0d tokens and %0d end statuses",
			items_sent, tokens_checked, finals_checked);
		$display("idling phases: none, sparse input, heavy stalls with hold-off, light both");
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
